>>> hdl/ufsf_pkg.sv
// Package for the union-find spanning forest block.
// Holds widths, the parent store word, and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package ufsf_pkg;

   localparam int NODES    = 1024;
   localparam int NODE_W   = $clog2(NODES);
   localparam int RANK_W   = 4;
   localparam int COUNT_W  = 10;
   localparam int WEIGHT_W = 32;

   localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } mem_word_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_COMPRESS,
      WR_LINK,
      WR_RANK
   } wr_kind_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_START,
      CUR_NEXT
   } cur_sel_type;

   typedef struct packed {
      logic        take_req;
      logic        side;
      cur_sel_type cur_sel;
      wr_kind_type wr_kind;
      logic        root_capture;
      logic        link_step;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic in_range;
      logic q_hits_cur;
      logic cur_is_root;
      logic roots_differ;
      logic rank_tie;
      logic clr_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hdl/ufsf_if.sv
// Valid/ready channel interfaces for edge requests and forest responses.
// Depends on ufsf_pkg for field widths.
`default_nettype none

interface ufsf_req_if
   import ufsf_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   source_node;
   logic [NODE_W-1:0]   target_node;
   logic [WEIGHT_W-1:0] edge_weight;
   logic                last_edge;

   modport source (output valid, source_node, target_node, edge_weight, last_edge,
                   input ready);
   modport sink   (input valid, source_node, target_node, edge_weight, last_edge,
                   output ready);
endinterface

interface ufsf_rsp_if
   import ufsf_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                taken;
   logic [NODE_W-1:0]   out_source;
   logic [NODE_W-1:0]   out_target;
   logic [WEIGHT_W-1:0] out_weight;
   logic [COUNT_W-1:0]  tree_edges;
   logic                list_done;

   modport source (output valid, taken, out_source, out_target, out_weight, tree_edges,
                   list_done, input ready);
   modport sink   (input valid, taken, out_source, out_target, out_weight, tree_edges,
                   list_done, output ready);
endinterface

`default_nettype wire

>>> hdl/ufsf_ctrl.sv
// Sequencer for the union-find forest: clearing pass, two root walks with
// path compression, join by rank and response hand-off. Depends on ufsf_pkg.
`default_nettype none

module ufsf_ctrl
   import ufsf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_status_type status,
   output      ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_FIND_RD,
      S_FIND_CHK,
      S_COMP_RD,
      S_COMP_WR,
      S_JOIN,
      S_RANK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;

   always_comb begin
      state_in         = state_ff;
      side_in          = side_ff;
      cmd              = '0;
      cmd.side         = side_ff;
      cmd.cur_sel      = CUR_HOLD;
      cmd.wr_kind      = WR_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_kind = WR_CLEAR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.take_req = 1'b1;
            if (status.req_valid) begin
               side_in  = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (!status.in_range) begin
               state_in = S_RESP;
            end else begin
               cmd.cur_sel = CUR_START;
               state_in    = S_FIND_RD;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (status.q_hits_cur) begin
               cmd.root_capture = 1'b1;
               cmd.cur_sel      = CUR_START;
               state_in         = S_COMP_RD;
            end else begin
               cmd.cur_sel = CUR_NEXT;
               state_in    = S_FIND_RD;
            end
         end
         S_COMP_RD: begin
            if (status.cur_is_root) begin
               if (!side_ff) begin
                  side_in  = 1'b1;
                  state_in = S_START;
               end else begin
                  state_in = S_JOIN;
               end
            end else begin
               state_in = S_COMP_WR;
            end
         end
         S_COMP_WR: begin
            cmd.wr_kind = WR_COMPRESS;
            cmd.cur_sel = CUR_NEXT;
            state_in    = S_COMP_RD;
         end
         S_JOIN: begin
            cmd.link_step = 1'b1;
            if (status.roots_differ) begin
               cmd.wr_kind = WR_LINK;
               state_in    = status.rank_tie ? S_RANK : S_RESP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RANK: begin
            cmd.wr_kind = WR_RANK;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ufsf_dp.sv
// Datapath for the union-find forest: parent/rank store, walk pointer, roots,
// edge latch, tree counter and response register. Depends on ufsf_pkg, ufsf_if.
`default_nettype none

module ufsf_dp
   import ufsf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   ufsf_req_if.sink           req,
   ufsf_rsp_if.source         rsp,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status
);

   mem_word_type mem [NODES];
   mem_word_type q_ff;

   logic [NODE_W-1:0]   src_ff, dst_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                last_ff;

   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   clr_ff;
   logic [NODE_W-1:0]   root_s_ff, root_d_ff;
   logic [RANK_W-1:0]   rank_s_ff, rank_d_ff;
   logic                taken_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic                out_valid_ff;
   logic                out_taken_ff;
   logic [NODE_W-1:0]   out_src_ff, out_dst_ff;
   logic [WEIGHT_W-1:0] out_weight_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_last_ff;

   logic                accept;
   logic [NODE_W-1:0]   start_node;
   logic [NODE_W-1:0]   side_root;
   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   mem_word_type        wr_data;
   logic                rank_lt;

   assign accept     = req.valid && cmd.take_req;
   assign req.ready  = cmd.take_req;
   assign start_node = cmd.side ? dst_ff : src_ff;
   assign side_root  = cmd.side ? root_d_ff : root_s_ff;
   assign rank_lt    = rank_s_ff < rank_d_ff;

   always_comb begin
      case (cmd.cur_sel)
         CUR_START: cur_in = start_node;
         CUR_NEXT:  cur_in = q_ff.parent;
         default:   cur_in = cur_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = '0;
      case (cmd.wr_kind)
         WR_CLEAR: begin
            wr_addr        = clr_ff;
            wr_data.parent = clr_ff;
         end
         WR_COMPRESS: begin
            // rank of a non-root is never read again
            wr_addr        = cur_ff;
            wr_data.parent = side_root;
         end
         WR_LINK: begin
            if (rank_lt) begin
               wr_addr        = root_s_ff;
               wr_data.rank   = rank_s_ff;
               wr_data.parent = root_d_ff;
            end else begin
               wr_addr        = root_d_ff;
               wr_data.rank   = rank_d_ff;
               wr_data.parent = root_s_ff;
            end
         end
         WR_RANK: begin
            wr_addr        = root_s_ff;
            wr_data.rank   = (rank_s_ff == RANK_MAX) ? rank_s_ff : rank_s_ff + 1'b1;
            wr_data.parent = root_s_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      q_ff <= mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (accept) begin
         src_ff    <= req.source_node;
         dst_ff    <= req.target_node;
         weight_ff <= req.edge_weight;
         last_ff   <= req.last_edge;
      end
      if (cmd.root_capture) begin
         if (cmd.side) begin
            root_d_ff <= cur_ff;
            rank_d_ff <= q_ff.rank;
         end else begin
            root_s_ff <= cur_ff;
            rank_s_ff <= q_ff.rank;
         end
      end
      if (cmd.out_load) begin
         out_taken_ff  <= taken_ff;
         out_src_ff    <= src_ff;
         out_dst_ff    <= dst_ff;
         out_weight_ff <= weight_ff;
         out_count_ff  <= count_ff;
         out_last_ff   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         taken_ff     <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_kind == WR_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (accept) begin
            taken_ff <= 1'b0;
         end else if (cmd.link_step) begin
            taken_ff <= status.roots_differ;
            if (status.roots_differ) count_ff <= count_ff + 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.req_valid    = req.valid;
   assign status.in_range     = (32'(src_ff) < NODES) && (32'(dst_ff) < NODES);
   assign status.q_hits_cur   = q_ff.parent == cur_ff;
   assign status.cur_is_root  = cur_ff == side_root;
   assign status.roots_differ = root_s_ff != root_d_ff;
   assign status.rank_tie     = rank_s_ff == rank_d_ff;
   assign status.clr_last     = clr_ff == NODE_W'(NODES - 1);
   assign status.out_free     = !out_valid_ff || rsp.ready;

   assign rsp.valid      = out_valid_ff;
   assign rsp.taken      = out_taken_ff;
   assign rsp.out_source = out_src_ff;
   assign rsp.out_target = out_dst_ff;
   assign rsp.out_weight = out_weight_ff;
   assign rsp.tree_edges = out_count_ff;
   assign rsp.list_done  = out_last_ff;

endmodule

`default_nettype wire

>>> hdl/union_find_spanning_forest.sv
// Union-find spanning forest, top level: sequencer plus datapath.
// One edge is handled at a time: req.ready is high only while idle, and a response is
// loaded once both root walks with path compression, the join and, when equal ranks
// join, the rank update are done; it waits while an earlier response is still held.
// Reset: synchronous; then a clearing pass over every node with req.ready low.
`default_nettype none

module union_find_spanning_forest
   import ufsf_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   ufsf_req_if.sink   req,
   ufsf_rsp_if.source rsp
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ufsf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ufsf_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .cmd    (cmd),
      .status (status)
   );

endmodule

`default_nettype wire

>>> hdl/ufsf_checker.sv
// Port-level checks for the union-find spanning forest, bound to the top level.
// Depends on ufsf_pkg and union_find_spanning_forest.
`default_nettype none

module ufsf_checker
   import ufsf_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_taken,
   input wire logic [NODE_W-1:0]   rsp_out_source,
   input wire logic [NODE_W-1:0]   rsp_out_target,
   input wire logic [WEIGHT_W-1:0] rsp_out_weight,
   input wire logic [COUNT_W-1:0]  rsp_tree_edges,
   input wire logic                rsp_list_done
);

   logic [COUNT_W-1:0] last_count_ff;
   logic [1:0]         pending_ff;
   logic               req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         pending_ff    <= '0;
      end else begin
         if (rsp_beat) last_count_ff <= rsp_tree_edges;
         pending_ff <= pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_taken)
         && $stable(rsp_out_source) && $stable(rsp_out_target)
         && $stable(rsp_out_weight) && $stable(rsp_tree_edges) && $stable(rsp_list_done))
      else $error("response beat changed while stalled");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tree_edges == last_count_ff + COUNT_W'(rsp_taken))
      else $error("tree edge count does not follow taken flags");

   a_no_self_loop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_taken |-> rsp_out_source != rsp_out_target)
      else $error("self loop reported as taken");

   a_pending: assert property (@(posedge clock) disable iff (reset)
      (pending_ff <= 2'd2) && (!rsp_valid || pending_ff != 2'd0))
      else $error("response without a matching request beat");

endmodule

bind union_find_spanning_forest ufsf_checker u_ufsf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_taken      (rsp.taken),
   .rsp_out_source (rsp.out_source),
   .rsp_out_target (rsp.out_target),
   .rsp_out_weight (rsp.out_weight),
   .rsp_tree_edges (rsp.tree_edges),
   .rsp_list_done  (rsp.list_done)
);

`default_nettype wire

>>> tb/sv/forest_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the spanning forest testbench: edge and response beat types, forest predictor.
// Depends on ufsf_pkg for widths and node count.

package forest_sb_pkg;

   import ufsf_pkg::*;

   typedef struct packed {
      logic [NODE_W-1:0]   source_node;
      logic [NODE_W-1:0]   target_node;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                last_edge;
   } edge_item_type;

   typedef struct packed {
      logic                taken;
      logic [NODE_W-1:0]   out_source;
      logic [NODE_W-1:0]   out_target;
      logic [WEIGHT_W-1:0] out_weight;
      logic [COUNT_W-1:0]  tree_edges;
      logic                list_done;
   } edge_result_type;

   class forest_scoreboard;
      logic [NODE_W-1:0]  parent_tbl [NODES];
      logic [RANK_W-1:0]  rank_tbl [NODES];
      logic [COUNT_W-1:0] joined_count;
      edge_result_type    expected_q [$];
      int unsigned        errors;
      int unsigned        checked;
      int unsigned        joins;
      int unsigned        top_rank;

      function new();
         for (int i = 0; i < NODES; i++) begin
            parent_tbl[i] = NODE_W'(i);
            rank_tbl[i]   = '0;
         end
         joined_count = '0;
         errors       = 0;
         checked      = 0;
         joins        = 0;
         top_rank     = 0;
      endfunction

      // root walk, then point every node on the path at the root
      function logic [NODE_W-1:0] find_and_compress(logic [NODE_W-1:0] node);
         logic [NODE_W-1:0] root;
         logic [NODE_W-1:0] cur;
         logic [NODE_W-1:0] nxt;
         int                steps;
         root  = node;
         steps = 0;
         while (parent_tbl[root] != root && steps < NODES) begin
            root = parent_tbl[root];
            steps++;
         end
         cur   = node;
         steps = 0;
         while (cur != root && steps < NODES) begin
            nxt             = parent_tbl[cur];
            parent_tbl[cur] = root;
            cur             = nxt;
            steps++;
         end
         return root;
      endfunction

      function void note_edge(edge_item_type e);
         edge_result_type   r;
         logic [NODE_W-1:0] rs;
         logic [NODE_W-1:0] rd;
         r.taken      = 1'b0;
         r.out_source = e.source_node;
         r.out_target = e.target_node;
         r.out_weight = e.edge_weight;
         r.list_done  = e.last_edge;
         if (int'(e.source_node) < NODES && int'(e.target_node) < NODES) begin
            rs = find_and_compress(e.source_node);
            rd = find_and_compress(e.target_node);
            if (rs != rd) begin
               if (rank_tbl[rs] < rank_tbl[rd]) begin
                  parent_tbl[rs] = rd;
               end else if (rank_tbl[rs] > rank_tbl[rd]) begin
                  parent_tbl[rd] = rs;
               end else begin
                  parent_tbl[rd] = rs;
                  if (rank_tbl[rs] != RANK_MAX) begin
                     rank_tbl[rs] = rank_tbl[rs] + 1'b1;
                  end
                  if (int'(rank_tbl[rs]) > top_rank) begin
                     top_rank = rank_tbl[rs];
                  end
               end
               joined_count = joined_count + 1'b1;
               r.taken      = 1'b1;
               joins++;
            end
         end
         r.tree_edges = joined_count;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [WEIGHT_W-1:0] want,
                                  logic [WEIGHT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(edge_result_type r);
         edge_result_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing outstanding: src 0x%0h dst 0x%0h",
                   r.out_source, r.out_target);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("taken",      want.taken,      r.taken);
         compare_field("out_source", want.out_source, r.out_source);
         compare_field("out_target", want.out_target, r.out_target);
         compare_field("out_weight", want.out_weight, r.out_weight);
         compare_field("tree_edges", want.tree_edges, r.tree_edges);
         compare_field("list_done",  want.list_done,  r.list_done);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for union_find_spanning_forest: drives edge beats, checks response beats.
// Depends on ufsf_pkg, ufsf_if and forest_sb_pkg.

module tb;

   import ufsf_pkg::*;
   import forest_sb_pkg::*;

   localparam longint TIMEOUT_NS = 64'd12_000_000;
   localparam int     BLOCK_SZ   = 64;
   localparam int     CALM_TAIL  = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufsf_req_if req_ch ();
   ufsf_rsp_if rsp_ch ();

   union_find_spanning_forest u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   forest_scoreboard sb = new();
   edge_item_type    edge_plan_q [$];
   int unsigned      edges_accepted = 0;
   bit               calm           = 1'b0;
   bit               pressure_done  = 1'b0;

   always #6 clock = ~clock;

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.source_node = '0;
      req_ch.target_node = '0;
      req_ch.edge_weight = '0;
      req_ch.last_edge   = 1'b0;
      rsp_ch.ready       = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin : monitor
      edge_item_type   item;
      edge_result_type res;
      if (!reset && req_ch.valid && req_ch.ready) begin
         item.source_node = req_ch.source_node;
         item.target_node = req_ch.target_node;
         item.edge_weight = req_ch.edge_weight;
         item.last_edge   = req_ch.last_edge;
         sb.note_edge(item);
         edges_accepted++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         res.taken      = rsp_ch.taken;
         res.out_source = rsp_ch.out_source;
         res.out_target = rsp_ch.out_target;
         res.out_weight = rsp_ch.out_weight;
         res.tree_edges = rsp_ch.tree_edges;
         res.list_done  = rsp_ch.list_done;
         sb.check_result(res);
      end
   end

   // response side back-pressure, with one long hold-off to fill the block
   initial begin : response_sink
      @(negedge clock);
      forever begin
         if (!pressure_done && edges_accepted >= 300) begin
            rsp_ch.ready = 1'b0;
            repeat (600) @(negedge clock);
            pressure_done = 1'b1;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
               repeat (200) @(negedge clock);
            end else begin
               repeat ($urandom_range(1, 30)) @(negedge clock);
            end
         end else begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
      end
   end

   function automatic edge_item_type mk_edge(int src, int dst, logic [WEIGHT_W-1:0] w,
                                             logic last);
      edge_item_type e;
      e.source_node = NODE_W'(src);
      e.target_node = NODE_W'(dst);
      e.edge_weight = w;
      e.last_edge   = last;
      return e;
   endfunction

   task automatic plan_block_edge(int a, int b);
      if ($urandom_range(0, 1) == 1) begin
         edge_plan_q.push_back(mk_edge(b, a, $urandom(), $urandom_range(0, 31) == 0));
      end else begin
         edge_plan_q.push_back(mk_edge(a, b, $urandom(), $urandom_range(0, 31) == 0));
      end
      if ($urandom_range(0, 9) == 0) begin
         edge_plan_q.push_back(mk_edge($urandom_range(0, NODES - 1),
                                       $urandom_range(0, NODES - 1), $urandom(),
                                       $urandom_range(0, 31) == 0));
      end
   endtask

   task automatic offer_edge(edge_item_type e, bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.source_node = e.source_node;
      req_ch.target_node = e.target_node;
      req_ch.edge_weight = e.edge_weight;
      req_ch.last_edge   = e.last_edge;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin : stimulus
      int  base;
      int  n;
      bit  steady;
      // directed: extreme nodes and weights, both join directions, ties, self loop,
      // same tree, and a deep path that must be compressed
      edge_plan_q.push_back(mk_edge(0, 1023, 32'h0000_0000, 1'b0));
      edge_plan_q.push_back(mk_edge(1023, 0, 32'hFFFF_FFFF, 1'b0));
      edge_plan_q.push_back(mk_edge(5, 5, 32'h5555_5555, 1'b0));
      edge_plan_q.push_back(mk_edge(2, 3, 32'hAAAA_AAAA, 1'b0));
      edge_plan_q.push_back(mk_edge(4, 2, 32'h0000_0001, 1'b0));
      edge_plan_q.push_back(mk_edge(2, 6, 32'h8000_0000, 1'b0));
      edge_plan_q.push_back(mk_edge(7, 8, 32'h7FFF_FFFF, 1'b0));
      edge_plan_q.push_back(mk_edge(8, 3, 32'h0000_FFFF, 1'b0));
      edge_plan_q.push_back(mk_edge(9, 10, 32'hFFFF_0000, 1'b0));
      edge_plan_q.push_back(mk_edge(11, 12, 32'h1234_5678, 1'b0));
      edge_plan_q.push_back(mk_edge(10, 12, 32'h8765_4321, 1'b0));
      edge_plan_q.push_back(mk_edge(12, 4, 32'hDEAD_BEEF, 1'b0));
      edge_plan_q.push_back(mk_edge(1, 1022, 32'h0F0F_0F0F, 1'b0));
      edge_plan_q.push_back(mk_edge(3, 1022, 32'hF0F0_F0F0, 1'b0));
      edge_plan_q.push_back(mk_edge(3, 9, 32'h3333_3333, 1'b0));
      edge_plan_q.push_back(mk_edge(1023, 1023, 32'hCCCC_CCCC, 1'b0));
      edge_plan_q.push_back(mk_edge(341, 682, 32'h0000_0002, 1'b0));
      edge_plan_q.push_back(mk_edge(512, 511, 32'hFFFF_FFFE, 1'b1));

      // per block: balanced merges build rank up to log2 of the block, then finds
      // over deep paths, then a join across blocks
      for (int blk = 0; blk < NODES / BLOCK_SZ; blk++) begin
         base = blk * BLOCK_SZ;
         for (int s = 1; s < BLOCK_SZ; s = s * 2) begin
            for (int i = 0; i < BLOCK_SZ; i += 2 * s) begin
               plan_block_edge(base + i + $urandom_range(0, s - 1),
                               base + i + s + $urandom_range(0, s - 1));
            end
         end
         repeat (4) begin
            plan_block_edge(base + $urandom_range(0, BLOCK_SZ - 1),
                            base + $urandom_range(0, BLOCK_SZ - 1));
         end
         plan_block_edge(base + $urandom_range(0, BLOCK_SZ - 1),
                         $urandom_range(0, NODES - 1));
      end
      edge_plan_q[edge_plan_q.size() - 1].last_edge = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      n = edge_plan_q.size();
      for (int i = 0; i < n; i++) begin
         if (i >= n - CALM_TAIL) begin
            calm = 1'b1;
         end
         steady = ((i / 100) % 4) == 3;
         offer_edge(edge_plan_q[i], !calm && !steady);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      $display("Run sent %0d edge beats over %0d nodes; %0d responses checked.",
               n, NODES, sb.checked);
      $display("Forest joins %0d, highest rank %0d, mismatches %0d.",
               sb.joins, sb.top_rank, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
